>>> hw/rtl/ffba_pkg.sv
// Shared types and codes for the first-fit block allocator.
`timescale 1ns / 1ps
`default_nettype none
package ffba_pkg;

    localparam int DW = 32;

    typedef enum logic [1:0] {
        REQ_ALLOC = 2'd0,
        REQ_FREE  = 2'd1,
        REQ_INIT  = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_GRANTED = 3'd0,
        ST_EVICTED = 3'd1,
        ST_FREED   = 3'd2,
        ST_NOSPACE = 3'd3,
        ST_BADADDR = 3'd4,
        ST_INIT    = 3'd5
    } t_status;

    // table cell operations
    typedef enum logic [2:0] {
        TOP_HOLD,
        TOP_WRITE,
        TOP_INS,
        TOP_DEL,
        TOP_INIT
    } t_top;

    // age cell operations
    typedef enum logic [1:0] {
        AOP_HOLD,
        AOP_WRITE,
        AOP_DEL
    } t_aop;

    typedef struct packed {
        logic [DW-1:0] start;
        logic [DW-1:0] size;
        logic          used;
    } t_entry;

    typedef struct packed {
        t_top          op;
        logic          we_used;
        logic          we_size;
        logic          wused;
        logic [DW-1:0] wstart;
        logic [DW-1:0] wsize;
    } t_tcmd;

    typedef struct packed {
        t_aop          op;
        logic [DW-1:0] wdata;
    } t_acmd;

endpackage
`default_nettype wire

>>> hw/rtl/ffba_cell.sv
// One entry of the address-ordered block table; shifts with its neighbors.
`timescale 1ns / 1ps
`default_nettype none
module ffba_cell
    import ffba_pkg::*;
#(
    parameter int IW  = 5,
    parameter int IDX = 0
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_tcmd         i_cmd,
    input  wire logic [IW-1:0] i_pos,
    input  wire t_entry        i_left,
    input  wire t_entry        i_right,
    output t_entry             o_entry
);

    localparam logic [IW-1:0] ME = IW'(IDX);

    logic          r_used, n_used;
    logic [DW-1:0] r_start, n_start;
    logic [DW-1:0] r_size, n_size;

    always_comb begin
        n_used  = r_used;
        n_start = r_start;
        n_size  = r_size;
        unique case (i_cmd.op)
            TOP_HOLD: ;
            TOP_WRITE: begin
                if (i_pos == ME) begin
                    if (i_cmd.we_used) n_used = i_cmd.wused;
                    if (i_cmd.we_size) n_size = i_cmd.wsize;
                end
            end
            TOP_INS: begin
                if (ME > i_pos) begin
                    n_used  = i_left.used;
                    n_start = i_left.start;
                    n_size  = i_left.size;
                end else if (ME == i_pos) begin
                    n_used  = 1'b0;
                    n_start = i_cmd.wstart;
                    n_size  = i_cmd.wsize;
                end
            end
            TOP_DEL: begin
                if (ME >= i_pos) begin
                    n_used  = i_right.used;
                    n_start = i_right.start;
                    n_size  = i_right.size;
                end
            end
            TOP_INIT: begin
                n_used = 1'b0;
                if (ME == '0) begin
                    n_start = '0;
                    n_size  = i_cmd.wsize;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
        end else begin
            r_used <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        r_start <= n_start;
        r_size  <= n_size;
    end

    assign o_entry = '{start: r_start, size: r_size, used: r_used};

endmodule
`default_nettype wire

>>> hw/rtl/ffba_age_cell.sv
// One slot of the allocation age list, oldest at slot zero.
`timescale 1ns / 1ps
`default_nettype none
module ffba_age_cell
    import ffba_pkg::*;
#(
    parameter int IW  = 5,
    parameter int IDX = 0
) (
    input  wire logic          i_clk,
    input  wire t_acmd         i_cmd,
    input  wire logic [IW-1:0] i_pos,
    input  wire logic [DW-1:0] i_right,
    output logic [DW-1:0]      o_data
);

    localparam logic [IW-1:0] ME = IW'(IDX);

    logic [DW-1:0] r_data, n_data;

    always_comb begin
        n_data = r_data;
        unique case (i_cmd.op)
            AOP_HOLD:  ;
            AOP_WRITE: if (i_pos == ME) n_data = i_cmd.wdata;
            AOP_DEL:   if (ME >= i_pos) n_data = i_right;
            default:   ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule
`default_nettype wire

>>> hw/rtl/first_fit_block_allocator.sv
// Top level: request sequencer over a chain of block-table cells and age cells.
// Each initialise, free or allocate request takes one transaction in and gives one or
// more result transactions out (tuser = status, tlast on the final one); request type
// three is dropped without a result, and initialise goes straight to its result. A free
// scans the table one entry per cycle, then the age list one slot per cycle, then marks
// the block free and merges it with a free left and a free right neighbour. An allocate
// scans the table one entry per cycle, then grants the block, may split off and merge the
// spare part, and records its age; each eviction on the way adds two table scans and the
// merge steps. Configuration registers: pool_bytes at 0x0, split_threshold at 0x4.
`timescale 1ns / 1ps
`default_nettype none
module first_fit_block_allocator
    import ffba_pkg::*;
#(
    parameter int MAX_BLOCKS   = 32,
    parameter int HEADER_BYTES = 24
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [63:0] i_s_tdata,   // [31:0] req_size, [63:32] block_addr
    input  wire logic [1:0]  i_s_tuser,   // [1:0] req_type
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [31:0]      o_m_tdata,   // [31:0] addr
    output logic [2:0]       o_m_tuser,   // [2:0] status
    output logic             o_m_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam logic [DW-1:0] HB   = DW'(HEADER_BYTES);
    localparam logic [CW-1:0] MAXB = CW'(MAX_BLOCKS);

    typedef enum logic [4:0] {
        S_IDLE, S_FSCAN, S_FAGE, S_REL0, S_RELL, S_RELLD, S_RELR, S_RELRD,
        S_ASCAN, S_AGRANT, S_AINS, S_AMRG, S_AMRGD, S_AAGE, S_EVICT, S_VSCAN,
        S_EMIT
    } t_state;

    t_state        r_state, r_ret;
    logic [DW-1:0] r_pool, r_thr;
    logic [DW-1:0] r_req, r_addr, r_key, r_size, r_start, r_extra;
    logic [CW-1:0] r_i, r_k, r_cnt, r_held;
    logic          r_evict;
    t_status       r_est;
    logic [DW-1:0] r_eaddr;
    logic          r_elast;
    logic          r_ovalid;
    t_status       r_ostat;
    logic [DW-1:0] r_oaddr;
    logic          r_olast;

    // configuration port
    assign pready = 1'b1;
    assign prdata = paddr[2] ? r_thr : r_pool;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool <= 32'd1048576;
            r_thr  <= 32'd4096;
        end else if (psel && penable && pwrite) begin
            if (paddr[2]) r_thr <= pwdata;
            else          r_pool <= pwdata;
        end
    end

    // cell rows
    t_entry        w_tbl [MAX_BLOCKS];
    logic [DW-1:0] w_age [MAX_BLOCKS];
    t_tcmd         c_tcmd;
    t_acmd         c_acmd;
    logic [IW-1:0] c_tpos, c_apos;

    for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_row
        t_entry        w_l, w_r;
        logic [DW-1:0] w_ar;
        if (g == 0) begin : g_first
            assign w_l = w_tbl[g];
        end else begin : g_mid
            assign w_l = w_tbl[g-1];
        end
        if (g == MAX_BLOCKS - 1) begin : g_last
            assign w_r  = w_tbl[g];
            assign w_ar = w_age[g];
        end else begin : g_notlast
            assign w_r  = w_tbl[g+1];
            assign w_ar = w_age[g+1];
        end
        ffba_cell #(.IW(IW), .IDX(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (c_tcmd),
            .i_pos   (c_tpos),
            .i_left  (w_l),
            .i_right (w_r),
            .o_entry (w_tbl[g])
        );
        ffba_age_cell #(.IW(IW), .IDX(g)) u_age (
            .i_clk   (i_clk),
            .i_cmd   (c_acmd),
            .i_pos   (c_apos),
            .i_right (w_ar),
            .o_data  (w_age[g])
        );
    end

    // single table read port, address picked by state
    logic [CW:0]   w_i1, w_i2;
    logic [IW-1:0] w_rdaddr;
    t_entry        w_rd;
    logic [DW-1:0] w_agek;

    assign w_i1 = {1'b0, r_i} + (CW+1)'(1);
    assign w_i2 = {1'b0, r_i} + (CW+1)'(2);

    always_comb begin
        unique case (r_state)
            S_RELL:  w_rdaddr = IW'(r_i - CW'(1));
            S_RELR:  w_rdaddr = IW'(w_i1);
            S_AMRG:  w_rdaddr = IW'(w_i2);
            default: w_rdaddr = IW'(r_i);
        endcase
    end

    assign w_rd   = w_tbl[w_rdaddr];
    assign w_agek = w_age[IW'(r_k)];

    logic w_accept, w_end, w_kend, w_hit, w_fit, w_left, w_right, w_mrg, w_split;
    assign w_accept = i_s_tvalid && o_s_tready;
    assign w_end    = (r_i == r_cnt);
    assign w_kend   = (r_k == r_held);
    assign w_hit    = w_rd.used && (w_rd.start == r_key);
    assign w_fit    = !w_rd.used && (w_rd.size >= r_req);
    assign w_left   = (r_i != '0) && !w_rd.used;
    assign w_right  = (w_i1 < {1'b0, r_cnt}) && !w_rd.used;
    assign w_mrg    = (w_i2 < {1'b0, r_cnt}) && !w_rd.used;
    assign w_split  = (r_extra > r_thr) && (r_extra >= HB) && (r_cnt < MAXB);

    // result of a finished release
    t_status       w_dst;
    logic [DW-1:0] w_daddr;
    t_state        w_dret;
    assign w_dst   = r_evict ? ST_EVICTED : ST_FREED;
    assign w_daddr = r_evict ? (r_key + HB) : r_addr;
    assign w_dret  = r_evict ? S_ASCAN : S_IDLE;

    // commands to the cell rows
    always_comb begin
        c_tcmd = '{op: TOP_HOLD, we_used: 1'b0, we_size: 1'b0, wused: 1'b0,
                   wstart: '0, wsize: '0};
        c_acmd = '{op: AOP_HOLD, wdata: r_start};
        c_tpos = IW'(r_i);
        c_apos = IW'(r_k);
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && (t_req'(i_s_tuser) == REQ_INIT)) begin
                    c_tcmd.op    = TOP_INIT;
                    c_tcmd.wsize = r_pool - HB;
                end
            end
            S_FAGE: begin
                if (!w_kend && (w_agek == r_key)) c_acmd.op = AOP_DEL;
            end
            S_REL0: begin
                c_tcmd.op      = TOP_WRITE;
                c_tcmd.we_used = 1'b1;
            end
            S_RELL: begin
                c_tpos = IW'(r_i - CW'(1));
                if (w_left) begin
                    c_tcmd.op      = TOP_WRITE;
                    c_tcmd.we_size = 1'b1;
                    c_tcmd.wsize   = w_rd.size + r_size + HB;
                end
            end
            S_RELLD: c_tcmd.op = TOP_DEL;
            S_RELR: begin
                if (w_right) begin
                    c_tcmd.op      = TOP_WRITE;
                    c_tcmd.we_size = 1'b1;
                    c_tcmd.wsize   = r_size + w_rd.size + HB;
                end
            end
            S_RELRD: begin
                c_tcmd.op = TOP_DEL;
                c_tpos    = IW'(w_i1);
            end
            S_AGRANT: begin
                c_tcmd.op      = TOP_WRITE;
                c_tcmd.we_used = 1'b1;
                c_tcmd.wused   = 1'b1;
                c_tcmd.we_size = w_split;
                c_tcmd.wsize   = r_req;
            end
            S_AINS: begin
                c_tcmd.op     = TOP_INS;
                c_tpos        = IW'(w_i1);
                c_tcmd.wstart = r_start + HB + r_req;
                c_tcmd.wsize  = r_extra - HB;
            end
            S_AMRG: begin
                c_tpos = IW'(w_i1);
                if (w_mrg) begin
                    c_tcmd.op      = TOP_WRITE;
                    c_tcmd.we_size = 1'b1;
                    // (extra - header) + next size + header
                    c_tcmd.wsize   = r_extra + w_rd.size;
                end
            end
            S_AMRGD: begin
                c_tcmd.op = TOP_DEL;
                c_tpos    = IW'(w_i2);
            end
            S_AAGE: begin
                c_apos = IW'(r_held);
                if (r_held < MAXB) c_acmd.op = AOP_WRITE;
            end
            S_EVICT: begin
                c_acmd.op = AOP_DEL;
                c_apos    = '0;
            end
            default: ;
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= S_IDLE;
            r_cnt    <= '0;
            r_held   <= '0;
            r_i      <= '0;
            r_k      <= '0;
            r_evict  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            // S_EMIT reloads the output register itself
            if (r_ovalid && i_m_tready && (r_state != S_EMIT)) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_req  <= i_s_tdata[31:0];
                        r_addr <= i_s_tdata[63:32];
                        r_key  <= i_s_tdata[63:32] - HB;
                        r_i    <= '0;
                        r_k    <= '0;
                        unique case (t_req'(i_s_tuser))
                            REQ_INIT: begin
                                r_cnt   <= (r_pool >= HB) ? CW'(1) : '0;
                                r_held  <= '0;
                                r_est   <= ST_INIT;
                                r_eaddr <= '0;
                                r_elast <= 1'b1;
                                r_ret   <= S_IDLE;
                                r_state <= S_EMIT;
                            end
                            REQ_FREE: begin
                                r_evict <= 1'b0;
                                if (i_s_tdata[63:32] < HB) begin
                                    r_est   <= ST_BADADDR;
                                    r_eaddr <= i_s_tdata[63:32];
                                    r_elast <= 1'b1;
                                    r_ret   <= S_IDLE;
                                    r_state <= S_EMIT;
                                end else begin
                                    r_state <= S_FSCAN;
                                end
                            end
                            REQ_ALLOC: r_state <= S_ASCAN;
                            REQ_NONE:  r_state <= S_IDLE;
                            default:   r_state <= S_IDLE;
                        endcase
                    end
                end
                S_FSCAN: begin
                    if (w_end) begin
                        r_est   <= ST_BADADDR;
                        r_eaddr <= r_addr;
                        r_elast <= 1'b1;
                        r_ret   <= S_IDLE;
                        r_state <= S_EMIT;
                    end else if (w_hit) begin
                        r_size  <= w_rd.size;
                        r_state <= S_FAGE;
                    end else begin
                        r_i <= r_i + CW'(1);
                    end
                end
                S_FAGE: begin
                    if (w_kend) begin
                        r_state <= S_REL0;
                    end else if (w_agek == r_key) begin
                        r_held  <= r_held - CW'(1);
                        r_state <= S_REL0;
                    end else begin
                        r_k <= r_k + CW'(1);
                    end
                end
                S_REL0: r_state <= S_RELL;
                S_RELL: begin
                    if (w_left) begin
                        r_size  <= w_rd.size + r_size + HB;
                        r_state <= S_RELLD;
                    end else begin
                        r_state <= S_RELR;
                    end
                end
                S_RELLD: begin
                    r_cnt   <= r_cnt - CW'(1);
                    r_i     <= r_i - CW'(1);
                    r_state <= S_RELR;
                end
                S_RELR: begin
                    if (w_right) begin
                        r_state <= S_RELRD;
                    end else begin
                        r_est   <= w_dst;
                        r_eaddr <= w_daddr;
                        r_elast <= !r_evict;
                        r_ret   <= w_dret;
                        r_state <= S_EMIT;
                    end
                end
                S_RELRD: begin
                    r_cnt   <= r_cnt - CW'(1);
                    r_est   <= w_dst;
                    r_eaddr <= w_daddr;
                    r_elast <= !r_evict;
                    r_ret   <= w_dret;
                    r_state <= S_EMIT;
                end
                S_ASCAN: begin
                    if (w_end) begin
                        if (r_held == '0) begin
                            r_est   <= ST_NOSPACE;
                            r_eaddr <= '0;
                            r_elast <= 1'b1;
                            r_ret   <= S_IDLE;
                            r_state <= S_EMIT;
                        end else begin
                            r_state <= S_EVICT;
                        end
                    end else if (w_fit) begin
                        r_start <= w_rd.start;
                        r_extra <= w_rd.size - r_req;
                        r_state <= S_AGRANT;
                    end else begin
                        r_i <= r_i + CW'(1);
                    end
                end
                S_AGRANT: r_state <= w_split ? S_AINS : S_AAGE;
                S_AINS: begin
                    r_cnt   <= r_cnt + CW'(1);
                    r_state <= S_AMRG;
                end
                S_AMRG: r_state <= w_mrg ? S_AMRGD : S_AAGE;
                S_AMRGD: begin
                    r_cnt   <= r_cnt - CW'(1);
                    r_state <= S_AAGE;
                end
                S_AAGE: begin
                    if (r_held < MAXB) r_held <= r_held + CW'(1);
                    r_est   <= ST_GRANTED;
                    r_eaddr <= r_start + HB;
                    r_elast <= 1'b1;
                    r_ret   <= S_IDLE;
                    r_state <= S_EMIT;
                end
                S_EVICT: begin
                    r_key   <= w_age[0];
                    r_held  <= r_held - CW'(1);
                    r_evict <= 1'b1;
                    r_i     <= '0;
                    r_state <= S_VSCAN;
                end
                S_VSCAN: begin
                    if (w_end) begin
                        r_est   <= ST_EVICTED;
                        r_eaddr <= r_key + HB;
                        r_elast <= 1'b0;
                        r_ret   <= S_ASCAN;
                        r_state <= S_EMIT;
                    end else if (w_hit) begin
                        r_size  <= w_rd.size;
                        r_state <= S_REL0;
                    end else begin
                        r_i <= r_i + CW'(1);
                    end
                end
                S_EMIT: begin
                    if (!r_ovalid || i_m_tready) begin
                        r_ovalid <= 1'b1;
                        r_ostat  <= r_est;
                        r_oaddr  <= r_eaddr;
                        r_olast  <= r_elast;
                        r_i      <= '0;
                        r_state  <= r_ret;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_oaddr;
    assign o_m_tuser  = r_ostat;
    assign o_m_tlast  = r_olast;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= MAXB)
        else $error("block count beyond table size");

    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= r_cnt)
        else $error("more held blocks than table entries");

    a_notlast_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !r_olast) |-> (r_ostat == ST_EVICTED))
        else $error("non-final result that is not an eviction");

    a_idle_empty_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && (r_ret == S_ASCAN)) |-> r_evict)
        else $error("retry scheduled outside an eviction");

endmodule
`default_nettype wire

>>> tb/first_fit_block_allocator_checker.sv
// Checker for the first-fit block allocator: predicts results and compares them.
`timescale 1ns / 1ps
module first_fit_block_allocator_checker
    import ffba_pkg::*;
#(
    parameter int MAX_BLOCKS   = 32,
    parameter int HEADER_BYTES = 24
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [63:0] i_s_tdata,   // [31:0] req_size, [63:32] block_addr
    input  wire logic [1:0]  i_s_tuser,   // [1:0] req_type
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [31:0] i_m_tdata,   // [31:0] addr
    input  wire logic [2:0]  i_m_tuser,   // [2:0] status
    input  wire logic        i_m_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        pready,
    output int               o_errors,
    output int               o_pending
);

    localparam logic [2:0] ADDR_POOL   = 3'h0;
    localparam logic [2:0] ADDR_THRESH = 3'h4;
    localparam logic [31:0] HB = HEADER_BYTES;

    typedef struct {
        t_status     status;
        logic [31:0] addr;
        logic        last;
    } t_result;

    t_result     expected_q[$];
    logic [31:0] pool_bytes;
    logic [31:0] split_thresh;
    logic [31:0] blk_start [MAX_BLOCKS];
    logic [31:0] blk_size  [MAX_BLOCKS];
    logic        blk_used  [MAX_BLOCKS];
    int          blk_cnt;
    logic [31:0] age_q[$];

    assign o_pending = expected_q.size();

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        o_errors++;
    endtask

    function automatic void push_result(t_status st, logic [31:0] a, logic l);
        t_result r;
        r.status = st;
        r.addr   = a;
        r.last   = l;
        expected_q.push_back(r);
    endfunction

    function automatic void tab_remove(int i);
        for (int k = i; k < blk_cnt - 1; k++) begin
            blk_start[k] = blk_start[k+1];
            blk_size[k]  = blk_size[k+1];
            blk_used[k]  = blk_used[k+1];
        end
        blk_cnt--;
    endfunction

    function automatic void tab_insert(int i, logic [31:0] st, logic [31:0] sz);
        for (int k = blk_cnt; k > i; k--) begin
            blk_start[k] = blk_start[k-1];
            blk_size[k]  = blk_size[k-1];
            blk_used[k]  = blk_used[k-1];
        end
        blk_start[i] = st;
        blk_size[i]  = sz;
        blk_used[i]  = 1'b0;
        blk_cnt++;
    endfunction

    function automatic void release_blk(int i);
        int j;
        j = i;
        blk_used[j] = 1'b0;
        if (j > 0 && !blk_used[j-1]) begin
            blk_size[j-1] = blk_size[j-1] + blk_size[j] + HB;
            tab_remove(j);
            j--;
        end
        if (j + 1 < blk_cnt && !blk_used[j+1]) begin
            blk_size[j] = blk_size[j] + blk_size[j+1] + HB;
            tab_remove(j + 1);
        end
    endfunction

    function automatic int find_held(logic [31:0] st);
        for (int i = 0; i < blk_cnt; i++)
            if (blk_used[i] && blk_start[i] == st)
                return i;
        return -1;
    endfunction

    function automatic void age_drop(logic [31:0] st);
        for (int i = 0; i < age_q.size(); i++) begin
            if (age_q[i] == st) begin
                age_q.delete(i);
                return;
            end
        end
    endfunction

    function automatic void predict_request(t_req kind, logic [31:0] req, logic [31:0] a);
        int          i;
        int          j;
        logic [31:0] extra;
        logic [31:0] victim;
        case (kind)
            REQ_INIT: begin
                blk_cnt = 0;
                age_q.delete();
                for (int k = 0; k < MAX_BLOCKS; k++) blk_used[k] = 1'b0;
                if (pool_bytes >= HB) begin
                    blk_start[0] = '0;
                    blk_size[0]  = pool_bytes - HB;
                    blk_cnt      = 1;
                end
                push_result(ST_INIT, '0, 1'b1);
            end
            REQ_FREE: begin
                j = -1;
                if (a >= HB) j = find_held(a - HB);
                if (j < 0) begin
                    push_result(ST_BADADDR, a, 1'b1);
                end else begin
                    age_drop(a - HB);
                    release_blk(j);
                    push_result(ST_FREED, a, 1'b1);
                end
            end
            REQ_ALLOC: begin
                forever begin
                    for (i = 0; i < blk_cnt; i++)
                        if (!blk_used[i] && blk_size[i] >= req) break;
                    if (i < blk_cnt) begin
                        extra = blk_size[i] - req;
                        blk_used[i] = 1'b1;
                        if (extra > split_thresh && extra >= HB && blk_cnt < MAX_BLOCKS) begin
                            blk_size[i] = req;
                            tab_insert(i + 1, blk_start[i] + HB + req, extra - HB);
                            if (i + 2 < blk_cnt && !blk_used[i+2]) begin
                                blk_size[i+1] = blk_size[i+1] + blk_size[i+2] + HB;
                                tab_remove(i + 2);
                            end
                        end
                        if (age_q.size() < MAX_BLOCKS) age_q.push_back(blk_start[i]);
                        push_result(ST_GRANTED, blk_start[i] + HB, 1'b1);
                        return;
                    end
                    if (age_q.size() == 0) begin
                        push_result(ST_NOSPACE, '0, 1'b1);
                        return;
                    end
                    victim = age_q.pop_front();
                    j = find_held(victim);
                    if (j >= 0) release_blk(j);
                    push_result(ST_EVICTED, victim + HB, 1'b0);
                end
            end
            default: ;  // type three is dropped without a result
        endcase
    endfunction

    initial begin
        o_errors     = 0;
        pool_bytes   = 32'd1048576;
        split_thresh = 32'd4096;
        blk_cnt      = 0;
        for (int k = 0; k < MAX_BLOCKS; k++) blk_used[k] = 1'b0;
    end

    always @(posedge i_clk) begin
        t_result r;
        if (i_rst_n) begin
            if (psel && penable && pwrite && pready) begin
                if (paddr == ADDR_POOL) pool_bytes = pwdata;
                else if (paddr == ADDR_THRESH) split_thresh = pwdata;
            end
            if (i_m_tvalid && i_m_tready) begin
                if (expected_q.size() == 0) begin
                    report("unexpected result, status", 32'(i_m_tuser), '0);
                end else begin
                    r = expected_q.pop_front();
                    if (i_m_tuser != r.status) report("status", 32'(i_m_tuser), 32'(r.status));
                    if (i_m_tdata != r.addr) report("addr", i_m_tdata, r.addr);
                    if (i_m_tlast != r.last) report("last", 32'(i_m_tlast), 32'(r.last));
                end
            end
            if (i_s_tvalid && i_s_tready)
                predict_request(t_req'(i_s_tuser), i_s_tdata[31:0], i_s_tdata[63:32]);
        end
    end

endmodule

>>> tb/first_fit_block_allocator_test.sv
// Testbench top for the first-fit block allocator: stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module first_fit_block_allocator_test;
    import ffba_pkg::*;

    localparam int          WATCHDOG_LIMIT = 20000;
    localparam int          DRAIN_CYCLES   = 200;
    localparam logic [2:0]  ADDR_POOL      = 3'h0;
    localparam logic [2:0]  ADDR_THRESH    = 3'h4;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [63:0] i_s_tdata;
    logic [1:0]  i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [31:0] o_m_tdata;
    logic [2:0]  o_m_tuser;
    logic        o_m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          errors;
    int          pending;
    int          idle_cycles;
    bit          no_gaps;
    bit          hold_sink;
    logic [31:0] held_addrs[$];

    first_fit_block_allocator u_dut (.*);

    first_fit_block_allocator_checker u_chk (
        .i_clk, .i_rst_n,
        .i_s_tvalid, .i_s_tready(o_s_tready), .i_s_tdata, .i_s_tuser,
        .i_m_tvalid(o_m_tvalid), .i_m_tready, .i_m_tdata(o_m_tdata),
        .i_m_tuser(o_m_tuser), .i_m_tlast(o_m_tlast),
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // addresses currently granted, used to build well-formed frees
    always @(posedge i_clk) begin
        if (o_m_tvalid && i_m_tready) begin
            if (o_m_tuser == ST_GRANTED) begin
                held_addrs.push_back(o_m_tdata);
            end else if (o_m_tuser == ST_EVICTED || o_m_tuser == ST_FREED) begin
                for (int i = 0; i < held_addrs.size(); i++)
                    if (held_addrs[i] == o_m_tdata) begin
                        held_addrs.delete(i);
                        break;
                    end
            end else if (o_m_tuser == ST_INIT) begin
                held_addrs.delete();
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // result sink
    initial begin
        int w;
        i_m_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            w = no_gaps ? 0 : $urandom_range(0, 7);
            if (hold_sink) begin
                w = 300;
                hold_sink = 1'b0;
            end
            if (w > 0) begin
                i_m_tready <= 1'b0;
                repeat (w) @(negedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
        end
    end

    task automatic send(input t_req kind, input logic [31:0] sz, input logic [31:0] a);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= {a, sz};
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
    endtask

    task automatic reg_write(input logic [2:0] a, input logic [31:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= a;
        pwdata  <= d;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // let the block drain, including work on a request that gives no result
    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic configure(input logic [31:0] pool, input logic [31:0] thr);
        settle();
        reg_write(ADDR_POOL, pool);
        reg_write(ADDR_THRESH, thr);
    endtask

    task automatic random_item(input logic [31:0] max_size);
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 55)
            send(REQ_ALLOC, $urandom_range(0, max_size), $urandom);
        else if (sel < 83 && held_addrs.size() > 0)
            send(REQ_FREE, $urandom, held_addrs[$urandom_range(0, held_addrs.size() - 1)]);
        else if (sel < 87)
            send(REQ_INIT, $urandom, $urandom);
        else if (sel < 90)
            send(REQ_NONE, $urandom, $urandom);
        else if (sel < 95)
            send(REQ_ALLOC, $urandom, $urandom);
        else
            send(REQ_FREE, $urandom, $urandom);
    endtask

    initial begin
        logic [31:0] pools [6];
        logic [31:0] thrs  [6];
        logic [31:0] sizes [6];
        pools = '{32'd2000, 32'd100000, 32'd5000, 32'hFFFF_FFFF, 32'd800, 32'd1048576};
        thrs  = '{32'd0, 32'd0, 32'd64, 32'hFFFF_FFFF, 32'd24, 32'd4096};
        sizes = '{32'd300, 32'd200, 32'd1500, 32'd100000, 32'd200, 32'd60000};
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = REQ_NONE;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        idle_cycles = 0;
        no_gaps     = 1'b0;
        hold_sink   = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // nothing initialised yet
        send(REQ_ALLOC, 32'd0, 32'd0);
        send(REQ_FREE, 32'hFFFF_FFFF, 32'd24);
        send(REQ_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        configure(32'd0, 32'd0);
        send(REQ_INIT, 32'd0, 32'd0);
        send(REQ_ALLOC, 32'd0, 32'd0);
        configure(32'd23, 32'hFFFF_FFFF);
        send(REQ_INIT, 32'd0, 32'd0);
        send(REQ_ALLOC, 32'd0, 32'd0);
        configure(32'd24, 32'd0);
        send(REQ_INIT, 32'd0, 32'd0);
        send(REQ_ALLOC, 32'd0, 32'd0);
        send(REQ_ALLOC, 32'd0, 32'd0);
        send(REQ_FREE, 32'd0, 32'd24);
        send(REQ_FREE, 32'd0, 32'd24);
        send(REQ_FREE, 32'd0, 32'd23);
        configure(32'hFFFF_FFFF, 32'd0);
        send(REQ_INIT, 32'd0, 32'd0);
        send(REQ_ALLOC, 32'hFFFF_FFFF, 32'd0);
        send(REQ_ALLOC, 32'd40, 32'd0);
        // spare space below a header: no split
        send(REQ_ALLOC, 32'hFFFF_FFFF - 32'd24 - 32'd40 - 32'd24 - 32'd10, 32'd0);
        send(REQ_ALLOC, 32'hFFFF_FFF0, 32'd0);
        send(REQ_FREE, 32'd0, 32'hFFFF_FFFF);
        send(REQ_INIT, 32'd0, 32'd0);

        for (int p = 0; p < 6; p++) begin
            configure(pools[p], thrs[p]);
            send(REQ_INIT, $urandom, $urandom);
            no_gaps = (p == 2);
            for (int n = 0; n < 50; n++) begin
                if (p == 1 && n == 10) hold_sink = 1'b1;
                if (p == 3 && n == 25) begin
                    i_s_tvalid <= 1'b0;
                    while (pending != 0) @(negedge i_clk);
                end
                random_item(sizes[p]);
            end
            no_gaps = 1'b0;
        end

        settle();
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/ffba_pkg.sv
hw/rtl/ffba_cell.sv
hw/rtl/ffba_age_cell.sv
hw/rtl/first_fit_block_allocator.sv
tb/first_fit_block_allocator_checker.sv
tb/first_fit_block_allocator_test.sv
